// ===== hdl/tvas_pkg.sv =====
// Package for the twin valve alternation sequencer: mode codes, register
// indexes, reset values of the configuration registers and the config struct.
// No dependencies; tvas_cfg_regs and the sequencer core import it.
package tvas_pkg;

  typedef enum logic [2:0] {
    MODE_INACTIVE   = 3'd0,
    MODE_LEFT_ONLY  = 3'd1,
    MODE_BOTH_LEFT  = 3'd2,
    MODE_RIGHT_ONLY = 3'd3,
    MODE_BOTH_RIGHT = 3'd4,
    MODE_LOW_SUPPLY = 3'd5
  } mode_t;

  localparam int unsigned CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_LEFT_OPEN  = 2'd0,
    REG_OVERLAP    = 2'd1,
    REG_RIGHT_OPEN = 2'd2,
    REG_LOW_THRESH = 2'd3
  } reg_idx_t;

  localparam logic [31:0] LEFT_OPEN_RST  = 32'd60000;
  localparam logic [31:0] OVERLAP_RST    = 32'd750;
  localparam logic [31:0] RIGHT_OPEN_RST = 32'd60000;
  localparam logic [15:0] LOW_THRESH_RST = 16'd1000;

  typedef struct packed {
    logic [31:0] left_open_ms;
    logic [31:0] overlap_ms;
    logic [31:0] right_open_ms;
    logic [15:0] low_supply_threshold;
  } tvas_cfg_t;

  // True for the four modes of the alternation cycle.
  function automatic logic is_cycling(mode_t m);
    return (m == MODE_LEFT_ONLY) || (m == MODE_BOTH_LEFT) ||
           (m == MODE_RIGHT_ONLY) || (m == MODE_BOTH_RIGHT);
  endfunction

endpackage

// ===== hdl/tvas_in_if.sv =====
// Input channel of the sequencer: one tick request with time, supply and enable.
// Valid/ready handshake; no package dependency.
interface tvas_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [15:0] supply_pressure;
  logic        enable_level;

  modport source (output valid, now_ms, supply_pressure, enable_level, input ready);
  modport sink   (input valid, now_ms, supply_pressure, enable_level, output ready);
endinterface

// ===== hdl/tvas_out_if.sv =====
// Result channel of the sequencer: valve drives, mode code and active flag.
// Valid/ready handshake; no package dependency.
interface tvas_out_if;
  logic       valid;
  logic       ready;
  logic       left_drive;
  logic       right_drive;
  logic [2:0] mode_code;
  logic       cycling_active;

  modport source (output valid, left_drive, right_drive, mode_code, cycling_active,
                  input ready);
  modport sink   (input valid, left_drive, right_drive, mode_code, cycling_active,
                  output ready);
endinterface

// ===== hdl/tvas_cfg_regs.sv =====
// APB-style configuration register file of the sequencer (four registers).
// Depends on tvas_pkg for register indexes, reset values and the config struct.
module tvas_cfg_regs
  import tvas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output tvas_cfg_t             cfg
);

  tvas_cfg_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  // The low address bits are ignored, so every write lands on one register.
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_open_ms         <= LEFT_OPEN_RST;
      cfg_r.overlap_ms           <= OVERLAP_RST;
      cfg_r.right_open_ms        <= RIGHT_OPEN_RST;
      cfg_r.low_supply_threshold <= LOW_THRESH_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT_OPEN:  cfg_r.left_open_ms         <= pwdata;
        REG_OVERLAP:    cfg_r.overlap_ms           <= pwdata;
        REG_RIGHT_OPEN: cfg_r.right_open_ms        <= pwdata;
        REG_LOW_THRESH: cfg_r.low_supply_threshold <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT_OPEN:  prdata = cfg_r.left_open_ms;
      REG_OVERLAP:    prdata = cfg_r.overlap_ms;
      REG_RIGHT_OPEN: prdata = cfg_r.right_open_ms;
      REG_LOW_THRESH: prdata = {16'd0, cfg_r.low_supply_threshold};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/twin_valve_alternation_sequencer_core.sv =====
// Twin valve alternation sequencer. An accepted request is held in the input register
// stage; its result then goes to the output register that drives the result channel.
// Throughput: one request per clock while the result channel is not stalled; the mode
// state is updated from the input register, so consecutive requests never wait on it.
// Reset (rst_n low, synchronous): mode inactive, disabled, both pipeline stages empty,
// configuration registers at their defaults. Uses tvas_pkg, the channels and tvas_cfg_regs.
module twin_valve_alternation_sequencer_core
  import tvas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tvas_in_if.sink               in_ch,
  tvas_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  tvas_cfg_t cfg;

  tvas_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input register stage.
  logic        s1_valid_r;
  logic [31:0] s1_now_r;
  logic [15:0] s1_supply_r;
  logic        s1_en_r;

  // Sequencer state.
  mode_t       mode_r, mode_nxt;
  logic [31:0] entered_r, entered_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic        timed_r, timed_nxt;
  logic        enabled_r, enabled_nxt;

  // Output register stage.
  logic        out_valid_r;
  logic        out_left_r, out_left_nxt;
  logic        out_right_r, out_right_nxt;
  mode_t       out_mode_r;
  logic        out_active_r, out_active_nxt;

  logic        s1_go;
  logic        in_go;

  // Mode after the enable edge has been applied.
  mode_t       en_mode;
  logic [31:0] en_entered;
  logic [31:0] en_hold;
  logic        en_timed;
  logic [31:0] elapsed;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_go       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_now_r    <= in_ch.now_ms;
      s1_supply_r <= in_ch.supply_pressure;
      s1_en_r     <= in_ch.enable_level;
    end
  end

  // Next-state logic: enable edge first, then low supply, recovery or expiry.
  always_comb begin
    en_mode    = mode_r;
    en_entered = entered_r;
    en_hold    = hold_r;
    en_timed   = timed_r;
    if (s1_en_r != enabled_r) begin
      en_mode    = s1_en_r ? MODE_LEFT_ONLY : MODE_INACTIVE;
      en_entered = s1_now_r;
      en_hold    = s1_en_r ? cfg.left_open_ms : 32'd0;
      en_timed   = s1_en_r;
    end
    elapsed = s1_now_r - en_entered;

    mode_nxt    = en_mode;
    entered_nxt = en_entered;
    hold_nxt    = en_hold;
    timed_nxt   = en_timed;
    enabled_nxt = s1_en_r;

    if (s1_en_r) begin
      priority if (s1_supply_r < cfg.low_supply_threshold) begin
        if (en_mode != MODE_LOW_SUPPLY) begin
          mode_nxt    = MODE_LOW_SUPPLY;
          entered_nxt = s1_now_r;
          hold_nxt    = 32'd0;
          timed_nxt   = 1'b0;
        end
      end else if (en_mode == MODE_LOW_SUPPLY) begin
        mode_nxt    = MODE_LEFT_ONLY;
        entered_nxt = s1_now_r;
        hold_nxt    = cfg.left_open_ms;
        timed_nxt   = 1'b1;
      end else if (en_timed && (elapsed >= en_hold)) begin
        entered_nxt = s1_now_r;
        unique case (en_mode)
          MODE_LEFT_ONLY: begin
            mode_nxt = MODE_BOTH_LEFT;
            hold_nxt = cfg.overlap_ms;
          end
          MODE_BOTH_LEFT: begin
            mode_nxt = MODE_RIGHT_ONLY;
            hold_nxt = cfg.right_open_ms;
          end
          MODE_RIGHT_ONLY: begin
            mode_nxt = MODE_BOTH_RIGHT;
            hold_nxt = cfg.overlap_ms;
          end
          MODE_BOTH_RIGHT: begin
            mode_nxt = MODE_LEFT_ONLY;
            hold_nxt = cfg.left_open_ms;
          end
          default: begin
            entered_nxt = en_entered;
          end
        endcase
      end else begin
        // The current mode has not run out yet, so it is kept.
      end
    end
  end

  // Output decode from the mode that this request leaves behind.
  always_comb begin
    unique case (mode_nxt)
      MODE_LEFT_ONLY: begin
        out_left_nxt  = 1'b1;
        out_right_nxt = 1'b0;
      end
      MODE_BOTH_LEFT, MODE_BOTH_RIGHT: begin
        out_left_nxt  = 1'b1;
        out_right_nxt = 1'b1;
      end
      MODE_RIGHT_ONLY: begin
        out_left_nxt  = 1'b0;
        out_right_nxt = 1'b1;
      end
      default: begin
        out_left_nxt  = 1'b0;
        out_right_nxt = 1'b0;
      end
    endcase
    out_active_nxt = is_cycling(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_INACTIVE;
      entered_r <= 32'd0;
      hold_r    <= 32'd0;
      timed_r   <= 1'b0;
      enabled_r <= 1'b0;
    end else if (s1_go) begin
      mode_r    <= mode_nxt;
      entered_r <= entered_nxt;
      hold_r    <= hold_nxt;
      timed_r   <= timed_nxt;
      enabled_r <= enabled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_left_r   <= out_left_nxt;
      out_right_r  <= out_right_nxt;
      out_mode_r   <= mode_nxt;
      out_active_r <= out_active_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_drive     = out_left_r;
  assign out_ch.right_drive    = out_right_r;
  assign out_ch.mode_code      = out_mode_r;
  assign out_ch.cycling_active = out_active_r;

  // While disabled the sequencer must sit in the inactive mode.
  a_disabled_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    !enabled_r |-> (mode_r == MODE_INACTIVE))
    else $error("sequencer left the inactive mode while disabled");

  // Exactly the four cycling modes carry a duration.
  a_timed_cycling: assert property (@(posedge clk) disable iff (!rst_n)
    timed_r == is_cycling(mode_r))
    else $error("timed flag disagrees with the mode");

  // The state moves only when a request is processed.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> ($stable(mode_r) && $stable(entered_r) && $stable(enabled_r)))
    else $error("sequencer state changed without a request");

  // Every processed request produces a pending result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("processed request produced no result");

endmodule
